// ----- design/vfr_pkg.sv -----
// ----------------------------------------------------------------------------
// vfr_pkg
// Shared widths, register indexes and the configuration bundle of the
// open-loop v/f ramp and phase generator.
// ----------------------------------------------------------------------------
package vfr_pkg;

	localparam int FREQ_W     = 28;            // q12.16 hertz
	localparam int FREQ_FRAC  = 16;
	localparam int FACT_W     = 32;            // factors, slope, multiplicand
	localparam int PPH_W      = 23;
	localparam int MI_W       = 16;
	localparam int PHASE_W    = 32;
	localparam int PROD_W     = FACT_W + FREQ_W;
	localparam int MUL_STEPS  = FREQ_W;        // one multiplier bit per cycle
	localparam int CNT_W      = $clog2(MUL_STEPS);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_TARGET_FREQ  = 3'd0;
	localparam cfg_idx_t REG_START_FREQ   = 3'd1;
	localparam cfg_idx_t REG_ACCEL_FACTOR = 3'd2;
	localparam cfg_idx_t REG_DECEL_FACTOR = 3'd3;
	localparam cfg_idx_t REG_MI_SLOPE     = 3'd4;
	localparam cfg_idx_t REG_PHASE_PER_HZ = 3'd5;

	localparam logic [FREQ_W-1:0] RST_TARGET_FREQ  = 28'd0;
	localparam logic [FREQ_W-1:0] RST_START_FREQ   = 28'd65536;
	localparam logic [FACT_W-1:0] RST_ACCEL_FACTOR = 32'h8000_0000;
	localparam logic [FACT_W-1:0] RST_DECEL_FACTOR = 32'hFFFF_FFFF;
	localparam logic [FACT_W-1:0] RST_MI_SLOPE     = 32'd0;
	localparam logic [PPH_W-1:0]  RST_PHASE_PER_HZ = 23'd0;

	typedef struct packed {
		logic [FREQ_W-1:0] target_freq;
		logic [FREQ_W-1:0] start_freq;
		logic [FACT_W-1:0] accel_factor;
		logic [FACT_W-1:0] decel_factor;
		logic [FACT_W-1:0] mi_slope;
		logic [PPH_W-1:0]  phase_per_hz;
	} cfg_regs_t;

endpackage

// ----- design/vfr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// vfr_cfg_regs
// Configuration register file, written by index, no read-back.
// ----------------------------------------------------------------------------
module vfr_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  vfr_pkg::cfg_idx_t                   cfg_idx,
	input  logic [vfr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output vfr_pkg::cfg_regs_t                  regs
);
	import vfr_pkg::*;

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.target_freq  <= RST_TARGET_FREQ;
			regs_q.start_freq   <= RST_START_FREQ;
			regs_q.accel_factor <= RST_ACCEL_FACTOR;
			regs_q.decel_factor <= RST_DECEL_FACTOR;
			regs_q.mi_slope     <= RST_MI_SLOPE;
			regs_q.phase_per_hz <= RST_PHASE_PER_HZ;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TARGET_FREQ:  regs_q.target_freq  <= cfg_wdata[FREQ_W-1:0];
				REG_START_FREQ:   regs_q.start_freq   <= cfg_wdata[FREQ_W-1:0];
				REG_ACCEL_FACTOR: regs_q.accel_factor <= cfg_wdata[FACT_W-1:0];
				REG_DECEL_FACTOR: regs_q.decel_factor <= cfg_wdata[FACT_W-1:0];
				REG_MI_SLOPE:     regs_q.mi_slope     <= cfg_wdata[FACT_W-1:0];
				REG_PHASE_PER_HZ: regs_q.phase_per_hz <= cfg_wdata[PPH_W-1:0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ----- design/vfr_sermul.sv -----
// ----------------------------------------------------------------------------
// vfr_sermul
// Bit-serial shift-add multiplier: one multiplier bit per step, lsb first.
// After MUL_STEPS steps prod holds the exact unsigned product.
// ----------------------------------------------------------------------------
module vfr_sermul (
	input  logic                              clk,
	input  logic                              load,
	input  logic                              step,
	input  logic [vfr_pkg::FACT_W-1:0]        a,
	input  logic [vfr_pkg::FREQ_W-1:0]        b,
	output logic [vfr_pkg::PROD_W-1:0]        prod
);
	import vfr_pkg::*;

	logic [FACT_W-1:0] a_q;
	logic [FREQ_W-1:0] b_q;
	logic [FACT_W-1:0] hi_q;
	logic [FREQ_W-1:0] lo_q;
	logic [FACT_W:0]   sum;

	assign sum = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : {(FACT_W+1){1'b0}});

	always_ff @(posedge clk) begin
		if (load) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (step) begin
			// partial sum shifts right, its lsb drops into the low word
			hi_q <= sum[FACT_W:1];
			lo_q <= {sum[0], lo_q[FREQ_W-1:1]};
			b_q  <= {1'b0, b_q[FREQ_W-1:1]};
		end
	end

	assign prod = {hi_q, lo_q};

endmodule

// ----- design/vf_ramp_phase_generator_top.sv -----
// ----------------------------------------------------------------------------
// vf_ramp_phase_generator_top
// Open-loop v/f ramp: per tick ramps frequency geometrically toward the
// target, derives the modulation index and advances the phase accumulator.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    restart
//   result    out        out_valid / out_ready  phase_angle, mod_index,
//                                               cur_freq, at_target
//   config    in         cfg_we                 cfg_idx, cfg_wdata
//
// One tick runs from accept through the serial ramp multiply, the clamp
// state, the index and phase multiplies running side by side, the output
// state and the idle state; a new tick is accepted only in the idle state.
// The serial multipliers handle one bit per cycle while they step.
// Reset clears frequency, phase and control, and loads the register defaults.
// A stalled result holds the block in its output state; the next beat is
// taken once the result register is free.
// ----------------------------------------------------------------------------
module vf_ramp_phase_generator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  vfr_pkg::cfg_idx_t                 cfg_idx,
	input  logic [vfr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [vfr_pkg::PHASE_W-1:0]       phase_angle,
	output logic [vfr_pkg::MI_W-1:0]          mod_index,
	output logic [vfr_pkg::FREQ_W-1:0]        cur_freq,
	output logic                              at_target
);
	import vfr_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_RAMP  = 5'b00010,
		ST_CLAMP = 5'b00100,
		ST_SCALE = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	cfg_regs_t          regs;
	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [FREQ_W-1:0]  freq_q;
	logic [PHASE_W-1:0] phase_q;
	logic               up_q;
	logic               down_q;
	logic               out_valid_q;
	logic [PHASE_W-1:0] phase_angle_q;
	logic [MI_W-1:0]    mod_index_q;
	logic [FREQ_W-1:0]  cur_freq_q;
	logic               at_target_q;

	logic               accept;
	logic               emit;
	logic               last_step;
	logic [FREQ_W-1:0]  f_start;
	logic               mul_load0;
	logic               mul_load1;
	logic               mul_step;
	logic [FACT_W-1:0]  mul_a0;
	logic [FREQ_W-1:0]  mul_b;
	logic [PROD_W-1:0]  prod0;
	logic [PROD_W-1:0]  prod1;
	logic [FREQ_W:0]    grown;
	logic [FREQ_W-1:0]  shrunk;
	logic [FREQ_W-1:0]  f_new;
	logic [MI_W-1:0]    mi_sat;
	logic [PHASE_W-1:0] phase_next;

	vfr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.regs      (regs)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign emit      = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign last_step = (cnt_q == CNT_W'(MUL_STEPS - 1));
	assign f_start   = restart ? regs.start_freq : freq_q;

	// lane 0 does the ramp multiply, then the index multiply
	assign mul_load0 = accept || (state_q == ST_CLAMP);
	assign mul_load1 = (state_q == ST_CLAMP);
	assign mul_step  = (state_q == ST_RAMP) || (state_q == ST_SCALE);
	assign mul_a0    = (state_q == ST_CLAMP) ? regs.mi_slope :
	                   (f_start < regs.target_freq) ? regs.accel_factor : regs.decel_factor;
	assign mul_b     = (state_q == ST_CLAMP) ? f_new : f_start;

	vfr_sermul u_mul0 (
		.clk  (clk),
		.load (mul_load0),
		.step (mul_step),
		.a    (mul_a0),
		.b    (mul_b),
		.prod (prod0)
	);

	vfr_sermul u_mul1 (
		.clk  (clk),
		.load (mul_load1),
		.step (mul_step),
		.a    ({{(FACT_W-PPH_W){1'b0}}, regs.phase_per_hz}),
		.b    (f_new),
		.prod (prod1)
	);

	// clamp so the ramp never passes the target
	assign grown  = prod0[PROD_W-1:FACT_W-1];
	assign shrunk = prod0[PROD_W-1:FACT_W];

	always_comb begin
		f_new = freq_q;
		if (up_q) begin
			f_new = (grown > {1'b0, regs.target_freq}) ? regs.target_freq : grown[FREQ_W-1:0];
		end else if (down_q) begin
			f_new = (shrunk < regs.target_freq) ? regs.target_freq : shrunk;
		end
	end

	assign mi_sat     = (prod0[PROD_W-1:FACT_W+MI_W] != '0) ? {MI_W{1'b1}}
	                                                         : prod0[FACT_W+MI_W-1:FACT_W];
	assign phase_next = phase_q + prod1[FREQ_FRAC+PHASE_W-1:FREQ_FRAC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			freq_q      <= '0;
			phase_q     <= '0;
			up_q        <= 1'b0;
			down_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						freq_q  <= f_start;
						if (restart) begin
							phase_q <= '0;
						end
						up_q    <= (f_start < regs.target_freq);
						down_q  <= (f_start > regs.target_freq);
						cnt_q   <= '0;
						state_q <= ST_RAMP;
					end
				end
				ST_RAMP: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					freq_q  <= f_new;
					cnt_q   <= '0;
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (emit) begin
						phase_q <= phase_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (emit) begin
			phase_angle_q <= phase_next;
			mod_index_q   <= mi_sat;
			cur_freq_q    <= freq_q;
			at_target_q   <= (freq_q == regs.target_freq);
		end
	end

	assign out_valid   = out_valid_q;
	assign phase_angle = phase_angle_q;
	assign mod_index   = mod_index_q;
	assign cur_freq    = cur_freq_q;
	assign at_target   = at_target_q;

endmodule
